@@ src/csecc_pkg.sv @@
// Shared types, constants and GF(2^8) helpers for the CD-ROM sector ECC generator.
package csecc_pkg;

	localparam int ADDR_W        = 12;
	localparam int STORE_DEPTH   = 2340;
	localparam int COVERED_BYTES = 2064;
	localparam int PARITY_BYTES  = 276;
	localparam int P_COLUMNS     = 86;
	localparam int P_LENGTH      = 24;
	localparam int P_STEP        = 2;
	localparam int Q_DIAGONALS   = 52;
	localparam int Q_LENGTH      = 43;
	localparam int Q_STRIDE      = 88;
	localparam int Q_OFFSET      = 172;
	localparam int MAJOR_W       = 7;
	localparam int MINOR_W       = 6;

	localparam logic [8:0] GF_POLY = 9'h11d;
	localparam logic [7:0] GF_INV3 = 8'hf4;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [7:0]        byte_t;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_COMPUTE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FIN_A,
		ST_FIN_B,
		ST_READ
	} state_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic finish;
	} acc_ctl_t;

	function automatic byte_t gf_times2(byte_t x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY[7:0] : 8'h00);
	endfunction

	function automatic byte_t gf_div3(byte_t v);
		byte_t acc;
		byte_t x;
		acc = 8'h00;
		x   = v;
		for (int i = 0; i < 8; i++) begin
			if (GF_INV3[i]) begin
				acc = acc ^ x;
			end
			x = gf_times2(x);
		end
		return acc;
	endfunction

endpackage

@@ src/csecc_mem.sv @@
// Sector image store: one write port, one registered read port.
module csecc_mem
	import csecc_pkg::*;
(
	input  logic  clk,
	input  logic  we,
	input  addr_t waddr,
	input  byte_t wdata,
	input  addr_t raddr,
	output byte_t rdata
);

	byte_t mem_q [0:STORE_DEPTH-1];
	byte_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/csecc_accum.sv @@
// Shared GF(2^8) codeword accumulator with final parity reduction.
module csecc_accum
	import csecc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  acc_ctl_t ctl,
	input  byte_t    rd_data,
	output byte_t    fin_value,
	output byte_t    sum_value
);

	byte_t accum_a_q;
	byte_t accum_b_q;

	assign fin_value = gf_div3(gf_times2(accum_a_q) ^ accum_b_q);
	assign sum_value = accum_a_q ^ accum_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_a_q <= 8'h00;
			accum_b_q <= 8'h00;
		end else if (ctl.clear) begin
			accum_a_q <= 8'h00;
			accum_b_q <= 8'h00;
		end else if (ctl.step) begin
			accum_a_q <= gf_times2(accum_a_q ^ rd_data);
			accum_b_q <= accum_b_q ^ rd_data;
		end else if (ctl.finish) begin
			accum_a_q <= fin_value;
		end
	end

endmodule

@@ src/cdrom_sector_ecc_generator_unit.sv @@
// Top level of the CD-ROM sector P/Q parity generator.
//
// Input channel (in_valid/in_stall) carries operation, position and byte_value.
// A load writes one covered byte (positions above 2063 are dropped) with no
// result. A read returns parity byte 0..275 through the ST_READ state and the
// output register; a position above 275 returns index_error with a zero byte.
// A compute walks the store with one shared accumulator and one memory port:
// each codeword is read over its length, followed by a read drain and two
// parity writes, for the 86 P columns and then the 52 Q diagonals; the finish
// result follows the last Q codeword. Q covers the P bytes just made.
// in_stall is high while a read or compute is in progress and while a result
// waits on a stalled output; the output register holds its transaction until
// out_stall is low. Reset clears the sequencer, accumulators and output valid;
// the sector store is not cleared and must be loaded before a compute.
module cdrom_sector_ecc_generator_unit
	import csecc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [11:0] position,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  parity_byte,
	output logic        index_error
);

	state_t state_q, state_d;

	logic               phase_q;
	logic [MAJOR_W-1:0] major_q;
	logic [MINOR_W-1:0] minor_q;
	addr_t              idx_q;
	addr_t              start_q;
	addr_t              wr_base_q;
	logic               acc_v_s1;
	logic               rd_err_q;
	logic               out_valid_q;
	logic               result_kind_q;
	byte_t              parity_byte_q;
	logic               index_error_q;

	logic               in_accept;
	logic               mem_we;
	addr_t              mem_waddr;
	byte_t              mem_wdata;
	addr_t              mem_raddr;
	byte_t              mem_rdata;
	acc_ctl_t           acc_ctl;
	byte_t              fin_value;
	byte_t              sum_value;

	logic [MAJOR_W-1:0] cur_count;
	logic [MINOR_W-1:0] cur_length;
	logic [MAJOR_W-1:0] cur_stride;
	logic [MAJOR_W-1:0] cur_step;
	addr_t              cur_span;
	addr_t              idx_sum;
	addr_t              idx_next;
	addr_t              start_next;
	logic               last_minor;
	logic               last_major;

	assign cur_count  = phase_q ? MAJOR_W'(Q_DIAGONALS) : MAJOR_W'(P_COLUMNS);
	assign cur_length = phase_q ? MINOR_W'(Q_LENGTH)    : MINOR_W'(P_LENGTH);
	assign cur_stride = phase_q ? MAJOR_W'(Q_STRIDE)    : MAJOR_W'(P_COLUMNS);
	assign cur_step   = phase_q ? MAJOR_W'(P_COLUMNS)   : MAJOR_W'(P_STEP);
	assign cur_span   = phase_q ? ADDR_W'(Q_DIAGONALS * Q_LENGTH)
	                            : ADDR_W'(P_COLUMNS * P_LENGTH);

	assign idx_sum    = idx_q + ADDR_W'(cur_stride);
	assign idx_next   = (idx_sum >= cur_span) ? idx_sum - cur_span : idx_sum;
	assign start_next = start_q + (major_q[0] ? ADDR_W'(cur_step - MAJOR_W'(1))
	                                          : ADDR_W'(1));
	assign last_minor = (minor_q == cur_length - MINOR_W'(1));
	assign last_major = (major_q == cur_count - MAJOR_W'(1));

	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	csecc_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	csecc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (acc_ctl),
		.rd_data   (mem_rdata),
		.fin_value (fin_value),
		.sum_value (sum_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mem_we        = 1'b0;
		mem_waddr     = wr_base_q;
		mem_wdata     = fin_value;
		mem_raddr     = idx_q;
		acc_ctl.clear = 1'b0;
		acc_ctl.step  = acc_v_s1;
		acc_ctl.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				mem_raddr = ADDR_W'(COVERED_BYTES) + position;
				mem_waddr = position;
				mem_wdata = byte_value;
				if (in_accept) begin
					case (operation)
						OP_LOAD: begin
							mem_we = (position < ADDR_W'(COVERED_BYTES));
						end
						OP_COMPUTE: begin
							acc_ctl.clear = 1'b1;
							state_d       = ST_WALK;
						end
						OP_READ: begin
							state_d = ST_READ;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (last_minor) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN_A;
			end
			ST_FIN_A: begin
				mem_we         = 1'b1;
				acc_ctl.finish = 1'b1;
				state_d        = ST_FIN_B;
			end
			ST_FIN_B: begin
				mem_we        = 1'b1;
				mem_waddr     = wr_base_q + ADDR_W'(cur_count);
				mem_wdata     = sum_value;
				acc_ctl.clear = 1'b1;
				state_d       = (last_major && phase_q) ? ST_IDLE : ST_WALK;
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			major_q     <= '0;
			minor_q     <= '0;
			idx_q       <= '0;
			start_q     <= '0;
			wr_base_q   <= '0;
			acc_v_s1    <= 1'b0;
			rd_err_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_v_s1 <= (state_q == ST_WALK);
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && operation == OP_COMPUTE) begin
						phase_q   <= 1'b0;
						major_q   <= '0;
						minor_q   <= '0;
						idx_q     <= '0;
						start_q   <= '0;
						wr_base_q <= ADDR_W'(COVERED_BYTES);
					end
					if (in_accept && operation == OP_READ) begin
						rd_err_q <= (position >= ADDR_W'(PARITY_BYTES));
					end
				end
				ST_WALK: begin
					idx_q   <= idx_next;
					minor_q <= minor_q + MINOR_W'(1);
				end
				ST_FIN_B: begin
					minor_q <= '0;
					if (last_major) begin
						if (phase_q) begin
							out_valid_q <= 1'b1;
						end else begin
							phase_q   <= 1'b1;
							major_q   <= '0;
							idx_q     <= '0;
							start_q   <= '0;
							wr_base_q <= ADDR_W'(COVERED_BYTES + Q_OFFSET);
						end
					end else begin
						major_q   <= major_q + MAJOR_W'(1);
						idx_q     <= start_next;
						start_q   <= start_next;
						wr_base_q <= wr_base_q + ADDR_W'(1);
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			result_kind_q <= KIND_READ;
			parity_byte_q <= rd_err_q ? 8'h00 : mem_rdata;
			index_error_q <= rd_err_q;
		end else if (state_q == ST_FIN_B && last_major && phase_q) begin
			result_kind_q <= KIND_DONE;
			parity_byte_q <= 8'h00;
			index_error_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = result_kind_q;
	assign parity_byte = parity_byte_q;
	assign index_error = index_error_q;

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_FIN_B))
		else $error("result raised without a finished transaction");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && index_error_q) |-> (parity_byte_q == 8'h00 && result_kind_q == KIND_READ))
		else $error("index error with nonzero parity byte");

	a_parity_area: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_A || state_q == ST_FIN_B) |->
		(mem_waddr >= ADDR_W'(COVERED_BYTES) && mem_waddr < ADDR_W'(STORE_DEPTH)))
		else $error("parity write outside parity area");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (idx_q < cur_span && minor_q < cur_length))
		else $error("walk index out of codeword span");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !out_valid_q)
		else $error("read finished while output register occupied");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the CD-ROM sector P/Q parity generator: directed and random commands.
module testbench;
	import csecc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic  kind;
		byte_t parity;
		logic  bad_index;
	} sector_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_LOAD;
	logic [11:0] position = '0;
	logic [7:0]  byte_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        result_kind;
	logic [7:0]  parity_byte;
	logic        index_error;

	byte_t         sector_image [STORE_DEPTH];
	sector_reply_t replies_due [$];
	int            fail_count = 0;
	int            burst_left = 0;
	int            stall_left = 0;
	int            stall_mode = 0;

	cdrom_sector_ecc_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.position   (position),
		.byte_value (byte_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_kind(result_kind),
		.parity_byte(parity_byte),
		.index_error(index_error)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic byte_t gf_double(byte_t x);
		logic [8:0] v;
		v = {x, 1'b0};
		if (v[8]) begin
			v = v ^ GF_POLY;
		end
		return v[7:0];
	endfunction

	function automatic byte_t gf_third(byte_t v);
		byte_t c;
		for (int i = 0; i < 256; i++) begin
			c = byte_t'(i);
			if ((c ^ gf_double(c)) == v) begin
				return c;
			end
		end
		return 8'h00;
	endfunction

	function automatic void encode_codewords(int count, int length, int major_step, int stride,
		int out_base);
		int    span;
		int    idx;
		byte_t acc_a;
		byte_t acc_b;
		byte_t t;
		span = count * length;
		for (int major = 0; major < count; major++) begin
			idx = (major >> 1) * major_step + (major & 1);
			acc_a = 8'h00;
			acc_b = 8'h00;
			for (int minor = 0; minor < length; minor++) begin
				t = sector_image[idx % STORE_DEPTH];
				idx = idx + stride;
				if (idx >= span) begin
					idx = idx - span;
				end
				acc_a = gf_double(acc_a ^ t);
				acc_b = acc_b ^ t;
			end
			acc_a = gf_third(gf_double(acc_a) ^ acc_b);
			sector_image[(COVERED_BYTES + out_base + major) % STORE_DEPTH] = acc_a;
			sector_image[(COVERED_BYTES + out_base + major + count) % STORE_DEPTH] = acc_a ^ acc_b;
		end
	endfunction

	function automatic void apply_sector_command(logic [1:0] op, addr_t pos, byte_t val);
		sector_reply_t r;
		case (op)
			OP_LOAD: begin
				if (pos < COVERED_BYTES) begin
					sector_image[pos] = val;
				end
			end
			OP_COMPUTE: begin
				encode_codewords(P_COLUMNS, P_LENGTH, P_STEP, P_COLUMNS, 0);
				encode_codewords(Q_DIAGONALS, Q_LENGTH, P_COLUMNS, Q_STRIDE, Q_OFFSET);
				r.kind = KIND_DONE;
				r.parity = 8'h00;
				r.bad_index = 1'b0;
				replies_due.push_back(r);
			end
			OP_READ: begin
				r.kind = KIND_READ;
				r.parity = (pos < PARITY_BYTES) ? sector_image[COVERED_BYTES + pos] : 8'h00;
				r.bad_index = (pos >= PARITY_BYTES);
				replies_due.push_back(r);
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_command(input logic [1:0] op, input addr_t pos, input byte_t val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		byte_value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_sector_command(op, pos, val);
	endtask

	task automatic fill_sector(input bit uniform, input byte_t fill_value);
		for (int p = 0; p < COVERED_BYTES; p++) begin
			send_command(OP_LOAD, addr_t'(p), uniform ? fill_value : byte_t'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_ignored_commands;
		send_command(OP_UNUSED, 12'd0, 8'h00);
		send_command(OP_UNUSED, 12'hfff, 8'hff);
		send_command(OP_LOAD, addr_t'(COVERED_BYTES), 8'h5a);
		send_command(OP_LOAD, 12'hfff, 8'hff);
		send_command(OP_READ, addr_t'(PARITY_BYTES), 8'h00);
		send_command(OP_READ, 12'hfff, 8'hff);
	endtask

	task automatic test_uniform_sector;
		fill_sector(1'b1, 8'hff);
		send_command(OP_COMPUTE, 12'd0, 8'h00);
		for (int p = 0; p < PARITY_BYTES; p++) begin
			send_command(OP_READ, addr_t'(p), 8'h00);
		end
	endtask

	task automatic test_boundaries;
		send_command(OP_LOAD, 12'd0, 8'hff);
		send_command(OP_LOAD, 12'd1, 8'h00);
		send_command(OP_LOAD, addr_t'(COVERED_BYTES - 2), 8'hff);
		send_command(OP_LOAD, addr_t'(COVERED_BYTES - 1), 8'h00);
		send_command(OP_COMPUTE, 12'hfff, 8'hff);
		send_command(OP_READ, 12'd0, 8'h00);
		send_command(OP_READ, addr_t'(P_COLUMNS - 1), 8'h00);
		send_command(OP_READ, addr_t'(P_COLUMNS), 8'h00);
		send_command(OP_READ, addr_t'(Q_OFFSET - 1), 8'h00);
		send_command(OP_READ, addr_t'(Q_OFFSET), 8'h00);
		send_command(OP_READ, addr_t'(Q_OFFSET + Q_DIAGONALS - 1), 8'h00);
		send_command(OP_READ, addr_t'(Q_OFFSET + Q_DIAGONALS), 8'h00);
		send_command(OP_READ, addr_t'(PARITY_BYTES - 1), 8'hff);
		send_command(OP_READ, addr_t'(PARITY_BYTES), 8'h00);
		send_command(OP_READ, 12'hfff, 8'h00);
		send_command(OP_COMPUTE, 12'd0, 8'h00);
		send_command(OP_READ, 12'd0, 8'h00);
		send_command(OP_READ, addr_t'(PARITY_BYTES - 1), 8'h00);
	endtask

	task automatic test_random_rounds;
		int counted;
		int round_len;
		int pick;
		byte_t val;
		counted = 0;
		while (counted < 600) begin
			round_len = $urandom_range(20, 100);
			repeat (round_len) begin
				pick = $urandom_range(0, 99);
				val = byte_t'($urandom_range(0, 255));
				if (pick < 55) begin
					if (pick < 5) begin
						val = pick[0] ? 8'hff : 8'h00;
					end
					send_command(OP_LOAD, addr_t'($urandom_range(0, COVERED_BYTES - 1)), val);
					counted++;
				end else if (pick < 85) begin
					send_command(OP_READ, addr_t'($urandom_range(0, PARITY_BYTES - 1)), val);
					counted++;
				end else if (pick < 90) begin
					send_command(OP_READ, addr_t'($urandom_range(PARITY_BYTES, 4095)), val);
					counted++;
				end else if (pick < 95) begin
					send_command(OP_LOAD, addr_t'($urandom_range(COVERED_BYTES, 4095)), val);
				end else begin
					send_command(OP_UNUSED, addr_t'($urandom_range(0, 4095)), val);
				end
			end
			send_command(OP_COMPUTE, addr_t'($urandom_range(0, 4095)), byte_t'($urandom_range(0, 255)));
			counted++;
			if ($urandom_range(0, 7) == 0) begin
				send_command(OP_COMPUTE, 12'd0, 8'h00);
				counted++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 600);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ((stall_left % 5) < 2);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		sector_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				$error("unexpected transaction: result_kind %0d parity_byte %0h index_error %0d",
					result_kind, parity_byte, index_error);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (result_kind !== want.kind) begin
					$error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
					fail_count++;
				end
				if (parity_byte !== want.parity) begin
					$error("parity_byte: expected %0h, actual %0h", want.parity, parity_byte);
					fail_count++;
				end
				if (index_error !== want.bad_index) begin
					$error("index_error: expected %0d, actual %0d", want.bad_index, index_error);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#12_000_000;
		$display("cdrom_sector_ecc_generator_unit: mismatch");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ignored_commands();
		test_uniform_sector();
		test_boundaries();
		test_random_rounds();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("cdrom_sector_ecc_generator_unit: match");
		end else begin
			$display("cdrom_sector_ecc_generator_unit: mismatch");
		end
		$finish;
	end

endmodule
